// ----- rtl/ppte_pkg.sv -----
// Package: shared constants, types and helper functions for the trajectory evaluator.
package ppte_pkg;

    localparam int SEGMENTS = 2;
    localparam int TERMS = 8;
    localparam int NAXES = 3;
    localparam int TABLE_DEPTH = NAXES * SEGMENTS * TERMS;
    localparam int TAB_AW = $clog2(TABLE_DEPTH);
    localparam int SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int BND_W = $clog2(SEGMENTS + 1);
    localparam int TERM_W = $clog2(TERMS);
    localparam int AXIS_W = 2;

    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_TIME = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic [SEG_W-1:0] seg;
        logic [31:0] t;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;

    // Saturating signed 64-bit add.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            sat_add = s[64] ? S64_MIN : S64_MAX;
        end
        else
        begin
            sat_add = s[63:0];
        end
    endfunction

    // Magnitude with sign back to saturated signed 64 bits.
    function automatic logic signed [63:0] from_mag(input logic [64:0] m, input logic neg);
        if (!neg)
        begin
            from_mag = (m > 65'h0_7FFF_FFFF_FFFF_FFFF) ? S64_MAX : m[63:0];
        end
        else if (m >= 65'h0_8000_0000_0000_0000)
        begin
            from_mag = S64_MIN;
        end
        else
        begin
            from_mag = -$signed(m[63:0]);
        end
    endfunction

    // Q16.48 to Q16.16, round half up, saturated.
    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        logic signed [64:0] w;
        logic signed [32:0] r;
        w = {v[63], v} + 65'sh0_8000_0000;
        r = w[64:32];
        if (r > 33'sh0_7FFF_FFFF)
        begin
            to_q16 = 32'h7FFF_FFFF;
        end
        else
        begin
            to_q16 = r[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            clamp_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            clamp_add = s[31:0];
        end
    endfunction

endpackage

// ----- rtl/ppte_ctrl.sv -----
// Controller: handshake, loads, origin latch, segment search and result hold.
module ppte_ctrl
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] operation,
    input  logic [3:0] segment_number,
    input  logic [31:0] time_stamp,
    input  logic [31:0] measured_x,
    input  logic [31:0] measured_y,
    output logic out_valid,
    input  logic out_stall,
    output logic [2:0] active_segment,
    output logic [31:0] origin_x,
    output logic [31:0] origin_y,
    output ppte_pkg::dp_cmd_t cmd,
    input  ppte_pkg::dp_stat_t stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    localparam int SEGMENTS_P1 = ppte_pkg::SEGMENTS + 1;

    logic [1:0] state_reg, state_next;
    logic started_reg;
    logic [31:0] origin_time_reg, origin_x_reg, origin_y_reg;
    logic [31:0] bnd_reg [SEGMENTS_P1];
    logic [31:0] e_reg;
    logic [ppte_pkg::SEG_W-1:0] seg_reg;
    logic [31:0] t_reg;
    logic start_reg;
    logic out_valid_reg;

    logic acc;
    logic out_free;
    logic [32:0] diff;
    logic [ppte_pkg::SEG_W-1:0] fseg;
    logic [31:0] ft;
    logic found;

    assign in_stall = (state_reg != ST_IDLE);
    assign acc = in_valid && !in_stall;
    // output register empty, or its item leaves at this edge
    assign out_free = !out_valid_reg || !out_stall;
    assign diff = {1'b0, time_stamp} - {1'b0, origin_time_reg};
    assign out_valid = out_valid_reg;
    assign active_segment = 3'(seg_reg);
    assign origin_x = origin_x_reg;
    assign origin_y = origin_y_reg;
    assign cmd.start = start_reg;
    assign cmd.seg = seg_reg;
    assign cmd.t = t_reg;

    always_comb
    begin
        found = 1'b0;
        fseg = '0;
        ft = '0;
        if (e_reg >= bnd_reg[ppte_pkg::SEGMENTS])
        begin
            fseg = ppte_pkg::SEG_W'(ppte_pkg::SEGMENTS - 1);
            if (bnd_reg[ppte_pkg::SEGMENTS] >= bnd_reg[ppte_pkg::SEGMENTS-1])
            begin
                ft = bnd_reg[ppte_pkg::SEGMENTS] - bnd_reg[ppte_pkg::SEGMENTS-1];
            end
        end
        else
        begin
            for (int i = 0; i < ppte_pkg::SEGMENTS; i++)
            begin
                if (!found && e_reg >= bnd_reg[i] && e_reg <= bnd_reg[i+1])
                begin
                    fseg = ppte_pkg::SEG_W'(i);
                    found = 1'b1;
                end
            end
            if (e_reg >= bnd_reg[fseg])
            begin
                ft = e_reg - bnd_reg[fseg];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && operation == ppte_pkg::OP_SAMPLE && started_reg)
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // hold until the previous result has left the output register
                if (out_free)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            started_reg <= 1'b0;
            origin_time_reg <= '0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_FIND) && out_free;
            if (state_reg == ST_EVAL && stat.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (acc && operation == ppte_pkg::OP_SAMPLE && !started_reg)
            begin
                started_reg <= 1'b1;
                origin_time_reg <= time_stamp;
                origin_x_reg <= measured_x;
                origin_y_reg <= measured_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && operation == ppte_pkg::OP_LOAD_TIME
            && segment_number <= 4'(ppte_pkg::SEGMENTS))
        begin
            bnd_reg[segment_number[ppte_pkg::BND_W-1:0]] <= time_stamp;
        end
        if (acc)
        begin
            e_reg <= diff[32] ? 32'd0 : diff[31:0];
        end
        if (state_reg == ST_FIND && out_free)
        begin
            seg_reg <= fseg;
            t_reg <= ft;
        end
    end

endmodule

// ----- rtl/ppte_dp.sv -----
// Datapath: coefficient memory and a shared Horner multiply-add unit.
module ppte_dp
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  logic [1:0] axis_select,
    input  logic [3:0] segment_number,
    input  logic [2:0] term_number,
    input  logic [63:0] coefficient_value,
    input  logic [31:0] origin_x,
    input  logic [31:0] origin_y,
    input  ppte_pkg::dp_cmd_t cmd,
    output ppte_pkg::dp_stat_t stat,
    output logic [31:0] command_x,
    output logic [31:0] command_y,
    output logic [31:0] command_z,
    output logic [31:0] velocity_x,
    output logic [31:0] velocity_y,
    output logic [31:0] velocity_z
);

    localparam int TW = ppte_pkg::TERM_W;
    localparam int AW = ppte_pkg::TAB_AW;

    logic [63:0] mem [ppte_pkg::TABLE_DEPTH];
    logic [63:0] rd_reg;
    logic busy_reg, done_reg;
    logic [1:0] axis_reg;
    logic [TW:0] k_reg;
    logic phase_reg;
    logic signed [63:0] p_reg, v_reg, cv_reg;
    logic [63:0] mag;
    logic [63:0] prod_lo, prod_hi;
    logic [96:0] prod;
    logic signed [63:0] mt;
    logic signed [67:0] ks;
    logic signed [63:0] kc;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [AW-1:0] rd_addr;
    logic rd_vld_reg;
    logic [TW:0] rk_reg;

    // write address
    logic [AW-1:0] wa;
    assign wa = AW'((32'(axis_select) * ppte_pkg::SEGMENTS + 32'(segment_number))
                * ppte_pkg::TERMS + 32'(term_number));

    assign rd_addr = AW'((32'(axis_reg) * ppte_pkg::SEGMENTS + 32'(cmd.seg))
                     * ppte_pkg::TERMS + 32'(k_reg[TW-1:0]));

    always_ff @(posedge clk)
    begin
        if (wr_en && axis_select < 2'd3 && segment_number < 4'(ppte_pkg::SEGMENTS))
        begin
            mem[wa] <= coefficient_value;
        end
        rd_reg <= mem[rd_addr];
    end

    // multiply unit: phase 0 uses p, phase 1 uses v
    logic signed [63:0] opnd;
    assign opnd = phase_reg ? v_reg : p_reg;
    assign mag = opnd[63] ? (64'd0 - opnd) : opnd;
    // magnitude is at most 2^63, so two 32x32 partial products cover it
    assign prod_lo = mag[31:0] * cmd.t;
    assign prod_hi = mag[63:32] * cmd.t;
    assign prod = {1'b0, prod_hi, 32'd0} + {33'd0, prod_lo};
    assign mt = (prod[96:16] > 81'(64'h7FFF_FFFF_FFFF_FFFF) + 81'(opnd[63]))
                ? (opnd[63] ? ppte_pkg::S64_MIN : ppte_pkg::S64_MAX)
                : ppte_pkg::from_mag(prod[80:16], opnd[63]);

    // k times coefficient, k = TERMS-1-term
    logic [3:0] kmul;
    assign kmul = 4'(ppte_pkg::TERMS - 1) - 4'(rk_reg);
    assign ks = $signed(cv_reg) * $signed({1'b0, kmul});
    assign kc = (ks > 68'sh0_7FFF_FFFF_FFFF_FFFF) ? ppte_pkg::S64_MAX
              : (ks < -68'sh0_8000_0000_0000_0000) ? ppte_pkg::S64_MIN : ks[63:0];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            axis_reg <= '0;
            k_reg <= '0;
            phase_reg <= 1'b0;
            rk_reg <= '0;
            cv_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                axis_reg <= '0;
                k_reg <= '0;
                rd_vld_reg <= 1'b0;
                phase_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (!rd_vld_reg)
                begin
                    rd_vld_reg <= 1'b1;
                    rk_reg <= k_reg;
                end
                else if (!phase_reg)
                begin
                    cv_reg <= rd_reg;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    rd_vld_reg <= 1'b0;
                    if (k_reg == (TW+1)'(ppte_pkg::TERMS - 1))
                    begin
                        k_reg <= '0;
                        if (axis_reg == 2'd2)
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
            end
        end
    end

    // accumulators: phase 1 of each term updates both p and v
    logic signed [63:0] pmul_reg;
    logic signed [63:0] pn, vn;
    always_comb
    begin
        if (rk_reg == '0)
        begin
            pn = cv_reg;
            vn = kc;
        end
        else
        begin
            pn = ppte_pkg::sat_add(pmul_reg, cv_reg);
            vn = (rk_reg == (TW+1)'(ppte_pkg::TERMS - 1)) ? v_reg
                 : ppte_pkg::sat_add(mt, kc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && rd_vld_reg && !phase_reg)
        begin
            pmul_reg <= mt;
        end
        if (busy_reg && rd_vld_reg && phase_reg)
        begin
            p_reg <= pn;
            v_reg <= vn;
            if (rk_reg == (TW+1)'(ppte_pkg::TERMS - 1))
            begin
                case (axis_reg)
                    2'd0:
                    begin
                        px_reg <= ppte_pkg::to_q16(pn);
                        vx_reg <= ppte_pkg::to_q16(vn);
                    end
                    2'd1:
                    begin
                        py_reg <= ppte_pkg::to_q16(pn);
                        vy_reg <= ppte_pkg::to_q16(vn);
                    end
                    default:
                    begin
                        pz_reg <= ppte_pkg::to_q16(pn);
                        vz_reg <= ppte_pkg::to_q16(vn);
                    end
                endcase
            end
        end
    end

    assign command_x = ppte_pkg::clamp_add(px_reg, origin_x);
    assign command_y = ppte_pkg::clamp_add(py_reg, origin_y);
    assign command_z = pz_reg;
    assign velocity_x = vx_reg;
    assign velocity_y = vy_reg;
    assign velocity_z = vz_reg;

endmodule

// ----- rtl/piecewise_poly_trajectory_eval.sv -----
// Top level: piecewise polynomial trajectory evaluator.
//   channel | signals                      | direction
//   input   | in_valid / in_stall, fields  | in
//   output  | out_valid / out_stall, fields| out
// Loads are written when accepted. A sample is evaluated by one shared Horner multiply
// unit stepping through the terms of each axis in turn; input is stalled in between, so
// the next item goes in only after the sample's result reaches the output registers.
// Reset clears control and origin; tables are undefined until written.
// A finished result waits in the output registers while loads go on; a further sample
// holds before evaluation until that result is taken.
module piecewise_poly_trajectory_eval
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] operation,
    input  logic [1:0] axis_select,
    input  logic [3:0] segment_number,
    input  logic [2:0] term_number,
    input  logic signed [63:0] coefficient_value,
    input  logic [31:0] time_stamp,
    input  logic signed [31:0] measured_x,
    input  logic signed [31:0] measured_y,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [31:0] command_x,
    output logic signed [31:0] command_y,
    output logic signed [31:0] command_z,
    output logic signed [31:0] velocity_x,
    output logic signed [31:0] velocity_y,
    output logic signed [31:0] velocity_z,
    output logic [2:0] active_segment
);

    ppte_pkg::dp_cmd_t cmd;
    ppte_pkg::dp_stat_t stat;
    logic [31:0] ox, oy;
    logic wr_en;

    // write coefficients when accepted
    assign wr_en = in_valid && !in_stall && operation == ppte_pkg::OP_LOAD_COEF;

    ppte_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .segment_number(segment_number),
        .time_stamp(time_stamp), .measured_x(measured_x), .measured_y(measured_y),
        .out_valid(out_valid), .out_stall(out_stall), .active_segment(active_segment),
        .origin_x(ox), .origin_y(oy), .cmd(cmd), .stat(stat)
    );

    ppte_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .axis_select(axis_select),
        .segment_number(segment_number), .term_number(term_number),
        .coefficient_value(coefficient_value), .origin_x(ox), .origin_y(oy),
        .cmd(cmd), .stat(stat), .command_x(command_x), .command_y(command_y),
        .command_z(command_z), .velocity_x(velocity_x), .velocity_y(velocity_y),
        .velocity_z(velocity_z)
    );

endmodule
